// File: rtl/core/mht_pkg.sv
`timescale 1ns / 1ps

package mht_pkg;

  // Token kinds
  localparam logic [1:0] KIND_PLAIN   = 2'd0;
  localparam logic [1:0] KIND_QUOTED  = 2'd1;
  localparam logic [1:0] KIND_COMMENT = 2'd2;

  // Special bytes
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_OPEN   = 8'd40;
  localparam logic [7:0] CH_CLOSE  = 8'd41;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_DEL    = 8'd127;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CHAR_A  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CHAR_B  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CHAR_C  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DELIM_CHAR_D  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIP_COMMENTS = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_QUOTED_TOKENS = 3'd6;

  localparam logic [2:0]  DELIM_MAX   = 3'd4;
  localparam logic [15:0] INDEX_LIMIT = 16'hFFFF;

  // One result beat
  typedef struct packed {
    logic [7:0]  tok_byte;
    logic        tok_end;
    logic [1:0]  tok_kind;
    logic [15:0] tok_index;
  } tok_t;

  // Result beats produced by one accepted byte, first goes out first
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

endpackage

// File: rtl/core/mht_if.sv
`timescale 1ns / 1ps

interface mht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface mht_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tok_byte;
  logic        tok_end;
  logic [1:0]  tok_kind;
  logic [15:0] tok_index;

  modport source (output valid, output tok_byte, output tok_end, output tok_kind,
                  output tok_index, input ready);
  modport sink   (input valid, input tok_byte, input tok_end, input tok_kind,
                  input tok_index, output ready);
endinterface

// File: rtl/core/mht_front.sv
`timescale 1ns / 1ps

module mht_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mht_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mht_pkg::CFG_DATA_W-1:0]   cfg_data,
  mht_in_if.sink                           hdr,
  input  logic                             space_ok,
  output mht_pkg::tok_pair_t               wr
);

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_ESC     = 3'd1;
  localparam logic [2:0] MODE_QUOTE   = 3'd2;
  localparam logic [2:0] MODE_QESC    = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;
  localparam logic [2:0] MODE_CESC    = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic               hv;
    logic [7:0]         hb;
    logic [1:0]         hk;
    logic [15:0]        cnt;
    mht_pkg::tok_pair_t res;
  } lex_t;

  // Configuration
  logic [2:0] delim_count;
  logic [7:0] delim_char_a;
  logic [7:0] delim_char_b;
  logic [7:0] delim_char_c;
  logic [7:0] delim_char_d;
  logic       skip_comments;
  logic       quoted_tokens;

  // Lexer state
  logic [2:0]  lex_mode;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic [1:0]  held_kind;
  logic [15:0] token_counter;

  logic [2:0]  lex_mode_next;
  logic        held_valid_next;
  logic [7:0]  held_byte_next;
  logic [1:0]  held_kind_next;
  logic [15:0] token_counter_next;

  logic       accept;
  logic [2:0] active_delims;
  logic       is_delim;
  lex_t       step;

  function automatic lex_t emit(lex_t s, logic [7:0] b, logic e, logic [1:0] k);
    lex_t r;
    mht_pkg::tok_t t;
    r = s;
    t.tok_byte  = b;
    t.tok_end   = e;
    t.tok_kind  = k;
    t.tok_index = s.cnt;
    if (s.res.count == 2'd0) begin
      r.res.first = t;
      r.res.count = 2'd1;
    end else if (s.res.count == 2'd1) begin
      r.res.second = t;
      r.res.count  = 2'd2;
    end
    return r;
  endfunction

  function automatic lex_t push_byte(lex_t s, logic [7:0] b, logic [1:0] k);
    lex_t r;
    r = s;
    if (s.hv) r = emit(r, s.hb, 1'b0, s.hk);
    r.hb = b;
    r.hk = k;
    r.hv = 1'b1;
    return r;
  endfunction

  function automatic lex_t close_token(lex_t s);
    lex_t r;
    r = s;
    if (s.hv) begin
      r = emit(r, s.hb, 1'b1, s.hk);
      r.hv = 1'b0;
      if (s.cnt != mht_pkg::INDEX_LIMIT) r.cnt = s.cnt + 16'd1;
    end
    return r;
  endfunction

  assign accept    = hdr.valid && space_ok;
  assign hdr.ready = space_ok;

  // Match against the active delimiters, count above four acts as four
  always_comb begin
    active_delims = (delim_count > mht_pkg::DELIM_MAX) ? mht_pkg::DELIM_MAX : delim_count;
    is_delim = (active_delims >= 3'd1 && hdr.in_byte == delim_char_a) ||
               (active_delims >= 3'd2 && hdr.in_byte == delim_char_b) ||
               (active_delims >= 3'd3 && hdr.in_byte == delim_char_c) ||
               (active_delims >= 3'd4 && hdr.in_byte == delim_char_d);
  end

  // Classify the byte and work out the state and the result beats
  always_comb begin
    logic [7:0] b;
    logic       keep_c;
    b           = hdr.in_byte;
    keep_c      = !skip_comments;
    step.mode   = lex_mode;
    step.hv     = held_valid;
    step.hb     = held_byte;
    step.hk     = held_kind;
    step.cnt    = token_counter;
    step.res    = '0;
    if (delim_count == 3'd0) begin
      if (hdr.in_last) begin
        step.hv   = 1'b0;
        step.mode = MODE_NORMAL;
        step.cnt  = 16'd0;
      end
    end else begin
      case (lex_mode)
        MODE_ESC: begin
          step      = push_byte(step, b, mht_pkg::KIND_PLAIN);
          step.mode = MODE_NORMAL;
        end
        MODE_QUOTE: begin
          step = push_byte(step, b, mht_pkg::KIND_QUOTED);
          if (b == mht_pkg::CH_BSLASH) begin
            step.mode = MODE_QESC;
          end else if (b == mht_pkg::CH_DQUOTE) begin
            step      = close_token(step);
            step.mode = MODE_NORMAL;
          end
        end
        MODE_QESC: begin
          step      = push_byte(step, b, mht_pkg::KIND_QUOTED);
          step.mode = MODE_QUOTE;
        end
        MODE_COMMENT: begin
          if (keep_c) step = push_byte(step, b, mht_pkg::KIND_COMMENT);
          if (b == mht_pkg::CH_BSLASH) begin
            step.mode = MODE_CESC;
          end else if (b == mht_pkg::CH_CLOSE) begin
            step      = close_token(step);
            step.mode = MODE_NORMAL;
          end
        end
        MODE_CESC: begin
          if (keep_c) step = push_byte(step, b, mht_pkg::KIND_COMMENT);
          step.mode = MODE_COMMENT;
        end
        default: begin
          step.mode = MODE_NORMAL;
          if ((b < mht_pkg::CH_SPACE && b != mht_pkg::CH_TAB) || b == mht_pkg::CH_DEL) begin
            // drop control bytes
          end else if (b == mht_pkg::CH_BSLASH) begin
            step      = push_byte(step, b, mht_pkg::KIND_PLAIN);
            step.mode = MODE_ESC;
          end else if (is_delim) begin
            step = close_token(step);
          end else if (b == mht_pkg::CH_DQUOTE && quoted_tokens) begin
            step      = close_token(step);
            step      = push_byte(step, b, mht_pkg::KIND_QUOTED);
            step.mode = MODE_QUOTE;
          end else if (b == mht_pkg::CH_OPEN) begin
            step = close_token(step);
            if (keep_c) step = push_byte(step, b, mht_pkg::KIND_COMMENT);
            step.mode = MODE_COMMENT;
          end else begin
            step = push_byte(step, b, mht_pkg::KIND_PLAIN);
          end
        end
      endcase
      if (hdr.in_last) begin
        step      = close_token(step);
        step.mode = MODE_NORMAL;
        step.cnt  = 16'd0;
      end
    end
  end

  // Advance the state only on an accepted beat
  always_comb begin
    lex_mode_next      = lex_mode;
    held_valid_next    = held_valid;
    held_byte_next     = held_byte;
    held_kind_next     = held_kind;
    token_counter_next = token_counter;
    wr                 = step.res;
    if (accept) begin
      lex_mode_next      = step.mode;
      held_valid_next    = step.hv;
      held_byte_next     = step.hb;
      held_kind_next     = step.hk;
      token_counter_next = step.cnt;
    end else begin
      wr.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode      <= MODE_NORMAL;
      held_valid    <= 1'b0;
      held_byte     <= 8'd0;
      held_kind     <= mht_pkg::KIND_PLAIN;
      token_counter <= 16'd0;
    end else begin
      lex_mode      <= lex_mode_next;
      held_valid    <= held_valid_next;
      held_byte     <= held_byte_next;
      held_kind     <= held_kind_next;
      token_counter <= token_counter_next;
    end
  end

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_count   <= 3'd0;
      delim_char_a  <= mht_pkg::CH_SPACE;
      delim_char_b  <= 8'd0;
      delim_char_c  <= 8'd0;
      delim_char_d  <= 8'd0;
      skip_comments <= 1'b0;
      quoted_tokens <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mht_pkg::REG_DELIM_COUNT:   delim_count   <= cfg_data[2:0];
        mht_pkg::REG_DELIM_CHAR_A:  delim_char_a  <= cfg_data;
        mht_pkg::REG_DELIM_CHAR_B:  delim_char_b  <= cfg_data;
        mht_pkg::REG_DELIM_CHAR_C:  delim_char_c  <= cfg_data;
        mht_pkg::REG_DELIM_CHAR_D:  delim_char_d  <= cfg_data;
        mht_pkg::REG_SKIP_COMMENTS: skip_comments <= cfg_data[0];
        mht_pkg::REG_QUOTED_TOKENS: quoted_tokens <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/mht_queue.sv
`timescale 1ns / 1ps

module mht_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  mht_pkg::tok_pair_t wr,
  output logic               space_ok,
  mht_out_if.source          tok
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_LIM = CNT_W'(DEPTH - 2);

  mht_pkg::tok_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] wr_ptr_1;
  logic [PTR_W-1:0] wr_ptr_2;
  logic             rd;
  mht_pkg::tok_t    head;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  // Room for the two beats one byte can make
  assign space_ok = (count <= FULL_LIM);

  assign wr_ptr_1 = bump(wr_ptr);
  assign wr_ptr_2 = bump(wr_ptr_1);
  assign rd       = tok.valid && tok.ready;

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (wr.count == 2'd1) wr_ptr_next = wr_ptr_1;
    if (wr.count == 2'd2) wr_ptr_next = wr_ptr_2;
    rd_ptr_next = rd ? bump(rd_ptr) : rd_ptr;
    count_next  = count + CNT_W'(wr.count) - CNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store the beats in order
  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) mem[wr_ptr] <= wr.first;
    if (wr.count == 2'd2) mem[wr_ptr_1] <= wr.second;
  end

  // Present the oldest beat
  assign head          = mem[rd_ptr];
  assign tok.valid     = (count != '0);
  assign tok.tok_byte  = head.tok_byte;
  assign tok.tok_end   = head.tok_end;
  assign tok.tok_kind  = head.tok_kind;
  assign tok.tok_index = head.tok_index;

endmodule

// File: rtl/core/mail_header_tokenizer_unit.sv
`timescale 1ns / 1ps

// Header tokenizer: takes one header byte per beat on hdr and returns token bytes on tok,
// each tagged with its kind, its token number and an end flag. The front takes one byte
// every cycle while the result queue has room for two beats; a byte that closes a token
// together with the byte before it (a closing quote or parenthesis, or the last byte of
// the string) makes two result beats, and the output drains one beat per ready cycle, so
// the sustained rate is one byte per cycle if results average no more than one beat per
// byte. A result beat is visible at tok at the earliest the cycle after its byte is
// accepted, later when older beats wait in the queue. Because the end flag needs the
// following byte, each token byte leaves with the next accepted byte that is kept or that
// ends a token, or with the in_last byte; dropped control and skipped comment bytes do
// not release it. The user writes configuration only while idle, unenforced by the block.
module mail_header_tokenizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mht_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mht_pkg::CFG_DATA_W-1:0]   cfg_data,
  mht_in_if.sink                           hdr,
  mht_out_if.source                        tok
);

  mht_pkg::tok_pair_t wr;
  logic               space_ok;

  mht_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hdr       (hdr),
    .space_ok  (space_ok),
    .wr        (wr)
  );

  mht_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .space_ok (space_ok),
    .tok      (tok)
  );

  // Beats are written only for an accepted byte
  assert property (@(posedge clk) disable iff (rst)
    wr.count != 2'd0 |-> hdr.valid && hdr.ready)
    else $error("result beats written without an accepted byte");

  // Two beats from one byte: the second one always ends a token
  assert property (@(posedge clk) disable iff (rst)
    wr.count == 2'd2 |-> wr.second.tok_end)
    else $error("bad pair of result beats");

  // A written beat is offered on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    wr.count != 2'd0 |=> tok.valid)
    else $error("queued beat not offered");

endmodule

// File: sim/mail_header_tokenizer_unit_tb.sv
`timescale 1ns / 1ps

module mail_header_tokenizer_unit_tb;
  import mht_pkg::*;

  typedef enum logic [2:0] {
    LX_NORMAL  = 3'd0,
    LX_ESC     = 3'd1,
    LX_QUOTE   = 3'd2,
    LX_QESC    = 3'd3,
    LX_COMMENT = 3'd4,
    LX_CESC    = 3'd5
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hdr_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mht_in_if  hdr_if ();
  mht_out_if tok_if ();

  mail_header_tokenizer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hdr       (hdr_if),
    .tok       (tok_if)
  );

  // Register shadows
  logic [2:0] delim_n;
  logic [7:0] delim_ch [4];
  logic       skip_c;
  logic       quote_on;

  // Lexer shadow state
  lex_mode_e   lx_mode;
  logic [7:0]  held_b;
  logic        held_v;
  logic [1:0]  held_k;
  logic [15:0] tok_num;

  tok_t      tok_expect [$];
  hdr_beat_t hdr_pending [$];
  logic [7:0] str_buf [$];

  int        items_queued = 0;
  int        items_taken = 0;
  int        errors = 0;
  int        tx_gap = 0;
  int        rx_stall = 0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;
  bit        rx_hold = 1'b0;
  bit        press_go = 1'b0;
  logic      in_taken = 1'b0;
  hdr_beat_t tx_next;
  tok_t      got;
  tok_t      want;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function void expect_beat(input logic [7:0] b, input logic e, input logic [1:0] k);
    tok_t t;
    t.tok_byte  = b;
    t.tok_end   = e;
    t.tok_kind  = k;
    t.tok_index = tok_num;
    tok_expect.push_back(t);
  endfunction

  // Release the held byte as a middle byte, then hold the new one
  function void hold_byte(input logic [7:0] b, input logic [1:0] k);
    if (held_v) expect_beat(held_b, 1'b0, held_k);
    held_b = b;
    held_k = k;
    held_v = 1'b1;
  endfunction

  // Release the held byte as the end of its token and advance the token number
  function void close_tok();
    if (held_v) begin
      expect_beat(held_b, 1'b1, held_k);
      held_v = 1'b0;
      if (tok_num != INDEX_LIMIT) tok_num = tok_num + 16'd1;
    end
  endfunction

  function bit is_delim(input logic [7:0] b);
    logic [2:0] n;
    n = (delim_n > DELIM_MAX) ? DELIM_MAX : delim_n;
    for (int i = 0; i < 4; i++)
      if (i < n && b == delim_ch[i]) return 1'b1;
    return 1'b0;
  endfunction

  function void lex_step(input logic [7:0] b, input logic last);
    logic keep;
    keep = !skip_c;
    // No active delimiter: swallow everything, clear on end of string
    if (delim_n == 3'd0) begin
      if (last) begin
        held_v  = 1'b0;
        lx_mode = LX_NORMAL;
        tok_num = 16'd0;
      end
      return;
    end
    case (lx_mode)
      LX_ESC: begin
        hold_byte(b, KIND_PLAIN);
        lx_mode = LX_NORMAL;
      end
      LX_QUOTE: begin
        hold_byte(b, KIND_QUOTED);
        if (b == CH_BSLASH) begin
          lx_mode = LX_QESC;
        end else if (b == CH_DQUOTE) begin
          close_tok();
          lx_mode = LX_NORMAL;
        end
      end
      LX_QESC: begin
        hold_byte(b, KIND_QUOTED);
        lx_mode = LX_QUOTE;
      end
      LX_COMMENT: begin
        if (keep) hold_byte(b, KIND_COMMENT);
        if (b == CH_BSLASH) begin
          lx_mode = LX_CESC;
        end else if (b == CH_CLOSE) begin
          close_tok();
          lx_mode = LX_NORMAL;
        end
      end
      LX_CESC: begin
        if (keep) hold_byte(b, KIND_COMMENT);
        lx_mode = LX_COMMENT;
      end
      default: begin
        lx_mode = LX_NORMAL;
        if ((b < CH_SPACE && b != CH_TAB) || b == CH_DEL) begin
          // drop control bytes
        end else if (b == CH_BSLASH) begin
          hold_byte(b, KIND_PLAIN);
          lx_mode = LX_ESC;
        end else if (is_delim(b)) begin
          close_tok();
        end else if (b == CH_DQUOTE && quote_on) begin
          close_tok();
          hold_byte(b, KIND_QUOTED);
          lx_mode = LX_QUOTE;
        end else if (b == CH_OPEN) begin
          close_tok();
          if (keep) hold_byte(b, KIND_COMMENT);
          lx_mode = LX_COMMENT;
        end else begin
          hold_byte(b, KIND_PLAIN);
        end
      end
    endcase
    if (last) begin
      close_tok();
      lx_mode = LX_NORMAL;
      tok_num = 16'd0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [7:0] pick_delim();
    case ($urandom_range(0, 7))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return 8'h2C;  // comma
      3: return 8'h3B;  // semicolon
      4: return 8'h3A;  // colon
      5: return 8'h3C;  // less-than
      6: return 8'h3E;  // greater-than
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DELIM_COUNT:   delim_n     = val[2:0];
      REG_DELIM_CHAR_A:  delim_ch[0] = val;
      REG_DELIM_CHAR_B:  delim_ch[1] = val;
      REG_DELIM_CHAR_C:  delim_ch[2] = val;
      REG_DELIM_CHAR_D:  delim_ch[3] = val;
      REG_SKIP_COMMENTS: skip_c      = val[0];
      REG_QUOTED_TOKENS: quote_on    = val[0];
      default: ;
    endcase
  endtask

  task set_config(input logic [2:0] n, input logic [7:0] a, input logic [7:0] b,
                  input logic [7:0] c, input logic [7:0] d, input logic s,
                  input logic q);
    write_reg(REG_DELIM_COUNT, {5'd0, n});
    write_reg(REG_DELIM_CHAR_A, a);
    write_reg(REG_DELIM_CHAR_B, b);
    write_reg(REG_DELIM_CHAR_C, c);
    write_reg(REG_DELIM_CHAR_D, d);
    write_reg(REG_SKIP_COMMENTS, {7'd0, s});
    write_reg(REG_QUOTED_TOKENS, {7'd0, q});
  endtask

  task put_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  // Move the staged string to the sender, flagging its final byte if asked
  task send_str(input bit with_last);
    hdr_beat_t it;
    while (str_buf.size() > 0) begin
      it.data = str_buf.pop_front();
      it.last = with_last && (str_buf.size() == 0);
      hdr_pending.push_back(it);
      items_queued++;
    end
  endtask

  // Mostly header-shaped segments, with escapes, control bytes and noise mixed in
  task build_random_str(input int nseg);
    int k;
    int n;
    int active;
    active = (delim_n > DELIM_MAX) ? DELIM_MAX : delim_n;
    for (int s = 0; s < nseg; s++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) str_buf.push_back(8'($urandom_range(33, 126)));
      end else if (k < 50) begin
        n = $urandom_range(1, 3);
        for (int j = 0; j < n; j++)
          str_buf.push_back((active == 0) ? CH_SPACE
                                          : delim_ch[$urandom_range(0, active - 1)]);
      end else if (k < 74) begin
        str_buf.push_back((k < 62) ? CH_DQUOTE : CH_OPEN);
        n = $urandom_range(0, 5);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 99) < 15) begin
            str_buf.push_back(CH_BSLASH);
            str_buf.push_back(8'($urandom_range(0, 255)));
          end else begin
            str_buf.push_back(8'($urandom_range(32, 126)));
          end
        end
        if ($urandom_range(0, 9) != 0) str_buf.push_back((k < 62) ? CH_DQUOTE : CH_CLOSE);
      end else if (k < 82) begin
        str_buf.push_back(CH_BSLASH);
        str_buf.push_back(8'($urandom_range(0, 255)));
      end else if (k < 90) begin
        str_buf.push_back(($urandom_range(0, 7) == 0) ? CH_DEL : 8'($urandom_range(0, 31)));
      end else begin
        str_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hold until every byte is taken and every predicted beat has come, then settle
  task wait_idle();
    while (items_taken != items_queued || tok_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    in_taken <= hdr_if.valid && hdr_if.ready;
    // Check result beats against the oldest prediction
    if (!rst && tok_if.valid && tok_if.ready) begin
      got.tok_byte  = tok_if.tok_byte;
      got.tok_end   = tok_if.tok_end;
      got.tok_kind  = tok_if.tok_kind;
      got.tok_index = tok_if.tok_index;
      if (tok_expect.size() == 0) begin
        errors++;
        $display("%0t tok beat: expected none, actual byte %h end %b kind %0d index %0d",
                 $time, got.tok_byte, got.tok_end, got.tok_kind, got.tok_index);
      end else begin
        want = tok_expect.pop_front();
        if (got !== want)  begin
          errors++;
          $display("%0t tok beat (byte end kind index): expected %h %b %0d %0d, actual %h %b %0d %0d",
                   $time, want.tok_byte, want.tok_end, want.tok_kind, want.tok_index,
                   got.tok_byte, got.tok_end, got.tok_kind, got.tok_index);
        end
      end
    end
    // Predict from each accepted header byte
    if (!rst && hdr_if.valid && hdr_if.ready) begin
      lex_step(hdr_if.in_byte, hdr_if.in_last);
      items_taken++;
    end
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      hdr_if.valid <= 1'b0;
    end else if (!hdr_if.valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        hdr_if.valid <= 1'b0;
      end else if (hdr_pending.size() > 0) begin
        tx_next = hdr_pending.pop_front();
        hdr_if.valid   <= 1'b1;
        hdr_if.in_byte <= tx_next.data;
        hdr_if.in_last <= tx_next.last;
        tx_gap = tx_burst ? 0 : idle_len();
      end else begin
        hdr_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, none in burst phases, forced off during the hold
  always @(negedge clk) begin
    if (rst || rx_hold) begin
      tok_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      tok_if.ready <= 1'b0;
    end else if (rx_burst || $urandom_range(0, 99) < 65) begin
      tok_if.ready <= 1'b1;
    end else begin
      rx_stall = idle_len();
      tok_if.ready <= 1'b0;
    end
  end

  // Long receiver hold while the sender keeps offering, so the block backs up
  initial begin
    wait (press_go);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    int start;
    int rnd_items;
    int phase;
    logic [2:0] n;

    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hdr_if.valid   = 1'b0;
    hdr_if.in_byte = 8'd0;
    hdr_if.in_last = 1'b0;
    tok_if.ready   = 1'b0;
    delim_n        = 3'd0;
    delim_ch[0]    = CH_SPACE;
    delim_ch[1]    = 8'd0;
    delim_ch[2]    = 8'd0;
    delim_ch[3]    = 8'd0;
    skip_c         = 1'b0;
    quote_on       = 1'b0;
    lx_mode        = LX_NORMAL;
    held_b         = 8'd0;
    held_v         = 1'b0;
    held_k         = KIND_PLAIN;
    tok_num        = 16'd0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Delimiter count zero out of reset: bytes vanish
    put_text("a (b)");
    send_str(1'b1);
    wait_idle();

    // Plain, escaped, quoted and comment tokens; byte right after a closing bracket
    set_config(3'd1, CH_SPACE, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    put_text("a\\\"\001\177\t \"b\\\"\"c(\\))d");
    send_str(1'b1);
    // Open quote and dangling escape cut off by end of string
    put_text("\"x");
    send_str(1'b1);
    put_text("y\\");
    send_str(1'b1);
    wait_idle();

    // Skip enabled halfway through a comment
    put_text("(e");
    send_str(1'b0);
    wait_idle();
    write_reg(REG_SKIP_COMMENTS, 8'd1);
    put_text("f)g");
    send_str(1'b1);
    wait_idle();

    // Count above four; control byte, quote, paren and backslash as delimiters
    set_config(3'd7, 8'h0A, CH_DQUOTE, CH_OPEN, CH_BSLASH, 1'b0, 1'b0);
    put_text("h\"i(j\\k\nl");
    send_str(1'b1);
    wait_idle();

    // Extreme delimiter values; nesting of quotes in comments and parens in quotes
    set_config(3'd4, 8'h00, 8'hFF, 8'h2C, CH_TAB, 1'b0, 1'b1);
    str_buf.push_back(8'h80);
    str_buf.push_back(8'hFF);
    str_buf.push_back(8'h00);
    put_text("(\"m\")\"(n)\"");
    send_str(1'b1);
    wait_idle();

    // Random phases, each with its own settings and idling mix
    rnd_items = 0;
    phase = 0;
    while (rnd_items < 1000) begin
      wait_idle();
      n = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4));
      set_config(n, pick_delim(), pick_delim(), pick_delim(), pick_delim(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        tx_burst = 1'b1;
        rx_burst = 1'b0;
        press_go = 1'b1;
      end
      start = items_queued;
      while (items_queued - start < 120) begin
        build_random_str($urandom_range(1, 8));
        send_str($urandom_range(0, 19) != 0);
      end
      rnd_items += items_queued - start;
      phase++;
    end

    // Drain
    while (items_taken != items_queued) @(posedge clk);
    for (int w = 0; w < 2000 && tok_expect.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tok_expect.size() != 0) begin
      errors += tok_expect.size();
      $display("%0t tok beat: expected byte %h end %b kind %0d index %0d, actual none",
               $time, tok_expect[0].tok_byte, tok_expect[0].tok_end,
               tok_expect[0].tok_kind, tok_expect[0].tok_index);
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
